// ===== hdl/hsrl_pkg.sv =====
package hsrl_pkg;

    localparam int ANGLE_W = 16;
    localparam int PI_Q13 = 25736;
    localparam int TWO_PI_Q13 = 51472;
    localparam int HALF_PI_Q20 = 1647099;
    localparam int ATAN_ENTRIES = 24;
    // cordic vector width: 33-bit difference scaled by 2^24, plus growth
    localparam int CW = 60;
    localparam int ZW = 24;
    // limiter working width
    localparam int LW = 20;
    // divider: |d| * 2^16 fits in 34 bits
    localparam int DIV_W = 34;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_CORDIC,
        ST_LIMIT,
        ST_DIV,
        ST_FINISH,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic prep;
        logic cordic_step;
        logic limit;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic cordic_done;
        logic need_div;
        logic div_done;
    } t_status;

    function automatic logic [ZW-1:0] atan_q20(input logic [4:0] i);
        logic [ZW-1:0] v;
        case (i)
            5'd0: v = 24'd823550;
            5'd1: v = 24'd486170;
            5'd2: v = 24'd256879;
            5'd3: v = 24'd130396;
            5'd4: v = 24'd65451;
            5'd5: v = 24'd32757;
            5'd6: v = 24'd16383;
            5'd7: v = 24'd8192;
            5'd8: v = 24'd4096;
            5'd9: v = 24'd2048;
            5'd10: v = 24'd1024;
            5'd11: v = 24'd512;
            5'd12: v = 24'd256;
            5'd13: v = 24'd128;
            5'd14: v = 24'd64;
            5'd15: v = 24'd32;
            5'd16: v = 24'd16;
            5'd17: v = 24'd8;
            5'd18: v = 24'd4;
            5'd19: v = 24'd2;
            5'd20: v = 24'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/hsrl_ctrl.sv =====
module hsrl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  hsrl_pkg::t_status i_status,
    output hsrl_pkg::t_cmd    o_cmd
);

    hsrl_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hsrl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            hsrl_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = hsrl_pkg::ST_PREP;
                end
            end
            hsrl_pkg::ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = hsrl_pkg::ST_CORDIC;
            end
            hsrl_pkg::ST_CORDIC: begin
                o_cmd.cordic_step = 1'b1;
                if (i_status.cordic_done) n_state = hsrl_pkg::ST_LIMIT;
            end
            hsrl_pkg::ST_LIMIT: begin
                o_cmd.limit = 1'b1;
                n_state = hsrl_pkg::ST_DIV;
            end
            hsrl_pkg::ST_DIV: begin
                if (!i_status.need_div || i_status.div_done) begin
                    n_state = hsrl_pkg::ST_FINISH;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            hsrl_pkg::ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = hsrl_pkg::ST_OUT;
            end
            hsrl_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = hsrl_pkg::ST_IDLE;
            end
            default: n_state = hsrl_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== hdl/hsrl_dp.sv =====
module hsrl_dp #(
    parameter int STEPS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [14:0]         i_cfg_data,
    input  logic signed [31:0]  i_look_x,
    input  logic signed [31:0]  i_look_y,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic [15:0]         i_step_time,
    input  hsrl_pkg::t_cmd      i_cmd,
    output hsrl_pkg::t_status   o_status,
    output logic signed [15:0]  o_heading,
    output logic signed [15:0]  o_heading_rate
);
    localparam int NSTEP = (STEPS < hsrl_pkg::ATAN_ENTRIES) ? STEPS : hsrl_pkg::ATAN_ENTRIES;
    localparam int CW = hsrl_pkg::CW;
    localparam int LW = hsrl_pkg::LW;
    localparam int DW = hsrl_pkg::DIV_W;

    logic [14:0] r_max_rate;
    logic signed [32:0] r_dx, r_dy;
    logic [15:0] r_dt;
    logic signed [CW-1:0] r_x, r_y;
    logic signed [hsrl_pkg::ZW-1:0] r_z;
    logic [4:0] r_iter;
    logic r_zero;
    logic signed [15:0] r_prev, r_prev_rate;
    logic signed [LW-1:0] r_yaw, r_limit;
    logic signed [16:0] r_rate;
    logic r_need_div, r_neg;
    logic [DW-1:0] r_rem, r_quo;
    logic [5:0] r_div_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_rate <= 15'd25736;
        end else if (i_cfg_we) begin
            r_max_rate <= i_cfg_data;
        end
    end

    // load and quadrant pre-rotation
    logic signed [CW-1:0] sx, sy;
    assign sx = CW'(r_dx) <<< 24;
    assign sy = CW'(r_dy) <<< 24;

    logic signed [CW-1:0] shx, shy;
    assign shx = r_x >>> r_iter;
    assign shy = r_y >>> r_iter;
    logic signed [hsrl_pkg::ZW-1:0] atan_v;
    assign atan_v = hsrl_pkg::ZW'(hsrl_pkg::atan_q20(r_iter));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dx <= 33'(i_look_x) - 33'(i_pos_x);
            r_dy <= 33'(i_look_y) - 33'(i_pos_y);
            r_dt <= i_step_time;
        end
        if (i_cmd.prep) begin
            r_iter <= '0;
            r_zero <= (r_dx == '0) && (r_dy == '0);
            r_limit <= LW'((32'(r_max_rate) * 32'(r_dt)) >> 16);
            if (r_dx < 0) begin
                if (r_dy >= 0) begin
                    r_x <= sy; r_y <= -sx; r_z <= hsrl_pkg::ZW'(hsrl_pkg::HALF_PI_Q20);
                end else begin
                    r_x <= -sy; r_y <= sx; r_z <= -hsrl_pkg::ZW'(hsrl_pkg::HALF_PI_Q20);
                end
            end else begin
                r_x <= sx; r_y <= sy; r_z <= '0;
            end
        end
        if (i_cmd.cordic_step) begin
            if (r_y > 0) begin
                r_x <= r_x + shy; r_y <= r_y - shx; r_z <= r_z + atan_v;
            end else begin
                r_x <= r_x - shy; r_y <= r_y + shx; r_z <= r_z - atan_v;
            end
            r_iter <= r_iter + 5'd1;
        end
    end
    assign o_status.cordic_done = (32'(r_iter) == NSTEP - 1);

    // limiter
    logic signed [hsrl_pkg::ZW-1:0] zr;
    logic signed [LW-1:0] target, d, last, yaw_m, yaw_p, rmax;
    assign zr = (r_z + hsrl_pkg::ZW'(64)) >>> 7;
    assign last = LW'(r_prev);
    assign target = r_zero ? last : LW'(zr);
    assign d = target - last;
    assign rmax = LW'({1'b0, r_max_rate});
    always_comb begin
        yaw_m = last - r_limit;
        if (yaw_m < -LW'(hsrl_pkg::PI_Q13)) yaw_m = yaw_m + LW'(hsrl_pkg::TWO_PI_Q13);
        yaw_p = last + r_limit;
        if (yaw_p > LW'(hsrl_pkg::PI_Q13)) yaw_p = yaw_p - LW'(hsrl_pkg::TWO_PI_Q13);
    end

    logic signed [LW-1:0] d_abs;
    assign d_abs = d < 0 ? -d : d;

    always_ff @(posedge i_clk) begin
        if (i_cmd.limit) begin
            r_need_div <= 1'b0;
            if (d > LW'(hsrl_pkg::PI_Q13)) begin
                r_yaw <= (d - LW'(hsrl_pkg::TWO_PI_Q13) < -r_limit) ? yaw_m : target;
                r_rate <= -17'(rmax);
            end else if (d < -LW'(hsrl_pkg::PI_Q13)) begin
                r_yaw <= (d + LW'(hsrl_pkg::TWO_PI_Q13) > r_limit) ? yaw_p : target;
                r_rate <= 17'(rmax);
            end else if (d < -r_limit) begin
                r_yaw <= yaw_m; r_rate <= -17'(rmax);
            end else if (d > r_limit) begin
                r_yaw <= yaw_p; r_rate <= 17'(rmax);
            end else begin
                r_yaw <= target;
                if (r_dt == '0) begin
                    r_rate <= (d > 0) ? 17'sd32767 : ((d < 0) ? -17'sd32768 : 17'sd0);
                end else begin
                    r_rate <= '0;
                    r_need_div <= (d != 0);
                end
            end
            r_neg <= d < 0;
            r_rem <= '0;
            r_quo <= DW'(d_abs) << 16;
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            // restoring division one quotient bit per cycle
            logic [DW:0] trial;
            trial = {r_rem, r_quo[DW-1]} - (DW+1)'(r_dt);
            if (!trial[DW]) begin
                r_rem <= trial[DW-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[DW-2:0], r_quo[DW-1]};
                r_quo <= {r_quo[DW-2:0], 1'b0};
            end
            r_div_cnt <= r_div_cnt + 6'd1;
        end
    end
    assign o_status.need_div = r_need_div;
    assign o_status.div_done = (32'(r_div_cnt) == DW);

    // saturated quotient
    logic signed [16:0] qrate;
    always_comb begin
        if (r_neg) qrate = (r_quo > DW'(32768)) ? -17'sd32768 : -17'(signed'({1'b0, r_quo[15:0]}));
        else qrate = (r_quo > DW'(32767)) ? 17'sd32767 : 17'(r_quo[15:0]);
        if (r_quo == DW'(32768) && r_neg) qrate = -17'sd32768;
    end

    logic signed [16:0] rate_f;
    assign rate_f = r_need_div ? qrate : r_rate;
    logic signed [LW-1:0] diff, yaw_f, ysum;
    logic signed [17:0] rsum;
    assign diff = (r_yaw - last) < 0 ? -(r_yaw - last) : (r_yaw - last);
    assign ysum = (last + r_yaw) >>> 1;
    assign yaw_f = (diff <= r_limit) ? ysum : r_yaw;
    assign rsum = (18'(r_prev_rate) + 18'(rate_f)) >>> 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_prev_rate <= '0;
        end else if (i_cmd.finish) begin
            r_prev <= (yaw_f > LW'(32767)) ? 16'sd32767 :
                      (yaw_f < -LW'(32768)) ? -16'sd32768 : yaw_f[15:0];
            r_prev_rate <= (rsum > 18'sd32767) ? 16'sd32767 :
                           (rsum < -18'sd32768) ? -16'sd32768 : rsum[15:0];
        end
    end

    assign o_heading = r_prev;
    assign o_heading_rate = r_prev_rate;

endmodule

// ===== hdl/heading_slew_rate_limiter.sv =====
// a transaction runs through load, pre-rotation, the cordic steps, the limiter, an optional rate divide and finish
// the cordic iterates one step a cycle, the rate divide one quotient bit a cycle
// only one transaction is in flight at a time, and its result waits for the output handshake
// next input is taken the cycle after the result transaction completes
// reset (synchronous, active low): max_rate to pi, stored heading and rate to zero
module heading_slew_rate_limiter #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [14:0]  i_cfg_data,      // max_rate
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [143:0] s_axis_tdata,    // look_x, look_y, pos_x, pos_y, step_time
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata     // heading, heading_rate
);

    hsrl_pkg::t_cmd cmd;
    hsrl_pkg::t_status status;
    logic signed [15:0] heading, heading_rate;

    hsrl_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_status(status), .o_cmd(cmd)
    );

    hsrl_dp #(.STEPS(CORDIC_STEPS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_look_x(s_axis_tdata[31:0]), .i_look_y(s_axis_tdata[63:32]),
        .i_pos_x(s_axis_tdata[95:64]), .i_pos_y(s_axis_tdata[127:96]),
        .i_step_time(s_axis_tdata[143:128]),
        .i_cmd(cmd), .o_status(status),
        .o_heading(heading), .o_heading_rate(heading_rate)
    );

    assign m_axis_tdata = {heading_rate, heading};

endmodule

// ===== hdl/hsrl_checker.sv =====
module hsrl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
    a_no_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid) else $error("result too early");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output dropped");
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid) else $error("valid after reset");
endmodule

bind heading_slew_rate_limiter hsrl_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
